/* sv/srt_pkg.sv */
// Shared types and codes for the sorted record table.
// Depends on nothing; every other file of the block but srt_ram imports it.
package srt_pkg;

    // Command codes carried in the request's cmd field.
    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_REMOVE   = 3'd1;
    localparam logic [2:0] CMD_LOOKUP   = 3'd2;
    localparam logic [2:0] CMD_UPDATE   = 3'd3;
    localparam logic [2:0] CMD_WITHDRAW = 3'd4;

    // Status codes returned with every result.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_SHORT     = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] key;
        logic [31:0] price_value;
        logic [31:0] amount;
    } srt_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] price_out;
        logic [31:0] stock_out;
        logic [31:0] withdrawals_out;
    } srt_out_t;

    // One stored record: one word of the record memory.
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] price;
        logic [31:0] stock;
        logic [31:0] withdrawals;
    } srt_rec_t;

    localparam int REC_W = $bits(srt_rec_t);

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD,
        DP_READ_MID,
        DP_COMPARE,
        DP_INS_START,
        DP_INS_MOVE,
        DP_INS_PUT,
        DP_REM_START,
        DP_REM_MOVE,
        DP_UPDATE,
        DP_WITHDRAW
    } srt_op_t;

    typedef struct packed {
        srt_op_t    op;
        logic       fill_inc;
        logic       fill_dec;
        logic       res_load;
        logic [2:0] res_status;
        logic       res_lookup;
    } srt_dp_cmd_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       cmd_bad;
        logic       search_done;
        logic       key_eq;
        logic       hit;
        logic       full;
        logic       short_stock;
        logic       ins_empty;
        logic       rem_none;
        logic       ins_more;
        logic       rem_more;
    } srt_dp_stat_t;

endpackage

/* sv/srt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srt_ram #(
    parameter int WIDTH = 160,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/srt_ctrl.sv */
// Command sequencer of the sorted record table: search, decision, shifting.
// Depends on srt_pkg for the command and status structs and codes.
module srt_ctrl import srt_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    output logic         result_valid,
    input  srt_dp_stat_t stat,
    output srt_dp_cmd_t  dp_cmd
);

    typedef enum logic [2:0] {
        IDLE,
        SEARCH,
        COMPARE,
        DECIDE,
        INS_MOVE,
        INS_PUT,
        REM_MOVE
    } state_t;

    state_t     state_reg, state_next;
    logic       done_reg, done_next;
    logic [2:0] res_status;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_status = ST_OK;
        dp_cmd.op         = DP_IDLE;
        dp_cmd.fill_inc   = 1'b0;
        dp_cmd.fill_dec   = 1'b0;
        dp_cmd.res_lookup = 1'b0;
        case (state_reg)
            IDLE:
            begin
                if (start)
                begin
                    dp_cmd.op  = DP_LOAD;
                    state_next = SEARCH;
                end
            end
            SEARCH:
            begin
                if (stat.cmd_bad)
                begin
                    done_next = 1'b1;
                end
                else if (stat.search_done)
                begin
                    state_next = DECIDE;
                end
                else
                begin
                    dp_cmd.op  = DP_READ_MID;
                    state_next = COMPARE;
                end
            end
            COMPARE:
            begin
                dp_cmd.op  = DP_COMPARE;
                state_next = stat.key_eq ? DECIDE : SEARCH;
            end
            DECIDE:
            begin
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (stat.hit)
                        begin
                            res_status = ST_DUPLICATE;
                            done_next  = 1'b1;
                        end
                        else if (stat.full)
                        begin
                            res_status = ST_FULL;
                            done_next  = 1'b1;
                        end
                        else if (stat.ins_empty)
                        begin
                            state_next = INS_PUT;
                        end
                        else
                        begin
                            dp_cmd.op  = DP_INS_START;
                            state_next = INS_MOVE;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!stat.hit)
                        begin
                            res_status = ST_NOT_FOUND;
                            done_next  = 1'b1;
                        end
                        else if (stat.rem_none)
                        begin
                            dp_cmd.fill_dec = 1'b1;
                            done_next       = 1'b1;
                        end
                        else
                        begin
                            dp_cmd.op  = DP_REM_START;
                            state_next = REM_MOVE;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (!stat.hit)
                        begin
                            res_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            dp_cmd.res_lookup = 1'b1;
                        end
                        done_next = 1'b1;
                    end
                    CMD_UPDATE:
                    begin
                        if (!stat.hit)
                        begin
                            res_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            dp_cmd.op = DP_UPDATE;
                        end
                        done_next = 1'b1;
                    end
                    default:
                    begin
                        if (!stat.hit)
                        begin
                            res_status = ST_NOT_FOUND;
                        end
                        else if (stat.short_stock)
                        begin
                            res_status = ST_SHORT;
                        end
                        else
                        begin
                            dp_cmd.op = DP_WITHDRAW;
                        end
                        done_next = 1'b1;
                    end
                endcase
            end
            INS_MOVE:
            begin
                dp_cmd.op = DP_INS_MOVE;
                if (!stat.ins_more)
                begin
                    state_next = INS_PUT;
                end
            end
            INS_PUT:
            begin
                dp_cmd.op       = DP_INS_PUT;
                dp_cmd.fill_inc = 1'b1;
                done_next       = 1'b1;
            end
            REM_MOVE:
            begin
                dp_cmd.op = DP_REM_MOVE;
                if (!stat.rem_more)
                begin
                    dp_cmd.fill_dec = 1'b1;
                    done_next       = 1'b1;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        if (done_next)
        begin
            state_next = IDLE;
        end
        dp_cmd.res_load   = done_next;
        dp_cmd.res_status = res_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy         = (state_reg != IDLE);
    assign result_valid = done_reg;

`ifndef NO_ASSERTIONS
    // An accepted transaction starts its search and never answers at once.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE && start) |=> (state_reg == SEARCH && !done_reg))
        else $error("accepted transaction did not enter the search");

    // Results are single-cycle strobes, never back to back.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe lasted more than one cycle");
`endif

endmodule

/* sv/srt_datapath.sv */
// Datapath of the sorted record table: record memory, search window,
// shift pointer, fill count and result register.
// Depends on srt_pkg and srt_ram.
module srt_datapath import srt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  srt_in_t      request,
    input  srt_dp_cmd_t  dp_cmd,
    output srt_dp_stat_t stat,
    output srt_out_t     result
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    srt_in_t       item_reg, item_next;
    srt_out_t      result_reg, result_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          hit_reg, hit_next;

    logic [CW-1:0] mid;
    logic [CW:0]   lo_w, ptr_w, fill_w;
    logic [CW:0]   lo_p1, ptr_m1, ptr_m2, ptr_p2, fill_m1;
    logic          key_lt;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [REC_W-1:0] rd_data;
    srt_rec_t      rd_rec, wr_rec;

    srt_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_rec = srt_rec_t'(rd_data);

    // Search midpoint and the widened pointer arithmetic for the shifts.
    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign lo_w    = {1'b0, lo_reg};
    assign ptr_w   = {1'b0, ptr_reg};
    assign fill_w  = {1'b0, fill_reg};
    assign lo_p1   = lo_w + (CW+1)'(1);
    assign ptr_m1  = ptr_w - (CW+1)'(1);
    assign ptr_m2  = ptr_w - (CW+1)'(2);
    assign ptr_p2  = ptr_w + (CW+1)'(2);
    assign fill_m1 = fill_w - (CW+1)'(1);
    assign key_lt  = (rd_rec.key < item_reg.key);

    assign stat.cmd         = item_reg.cmd;
    assign stat.cmd_bad     = (item_reg.cmd > CMD_WITHDRAW);
    assign stat.search_done = (lo_reg >= hi_reg);
    assign stat.key_eq      = (rd_rec.key == item_reg.key);
    assign stat.hit         = hit_reg;
    assign stat.full        = (fill_reg == DEPTH_C);
    assign stat.short_stock = (rd_rec.stock < item_reg.amount);
    assign stat.ins_empty   = (fill_reg == lo_reg);
    assign stat.rem_none    = (lo_p1 >= fill_w);
    assign stat.ins_more    = (ptr_m1 > lo_w);
    assign stat.rem_more    = (ptr_p2 < fill_w);

    always_comb
    begin
        item_next = item_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        ptr_next  = ptr_reg;
        hit_next  = hit_reg;
        fill_next = fill_reg;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = lo_reg[AW-1:0];
        wr_rec    = rd_rec;
        case (dp_cmd.op)
            DP_LOAD:
            begin
                item_next = request;
                lo_next   = '0;
                hi_next   = fill_reg;
                hit_next  = 1'b0;
            end
            DP_READ_MID:
            begin
                rd_en   = 1'b1;
                rd_addr = mid[AW-1:0];
            end
            DP_COMPARE:
            begin
                if (stat.key_eq)
                begin
                    // The slot of a hit is kept in lo.
                    hit_next = 1'b1;
                    lo_next  = mid;
                end
                else if (key_lt)
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
            end
            DP_INS_START:
            begin
                rd_en    = 1'b1;
                rd_addr  = fill_m1[AW-1:0];
                ptr_next = fill_reg;
            end
            DP_INS_MOVE:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AW-1:0];
                rd_en    = stat.ins_more;
                rd_addr  = ptr_m2[AW-1:0];
                ptr_next = ptr_m1[CW-1:0];
            end
            DP_INS_PUT:
            begin
                wr_en              = 1'b1;
                wr_rec.key         = item_reg.key;
                wr_rec.price       = item_reg.price_value;
                wr_rec.stock       = item_reg.amount;
                wr_rec.withdrawals = '0;
            end
            DP_REM_START:
            begin
                rd_en    = 1'b1;
                rd_addr  = lo_p1[AW-1:0];
                ptr_next = lo_reg;
            end
            DP_REM_MOVE:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[AW-1:0];
                rd_en    = stat.rem_more;
                rd_addr  = ptr_p2[AW-1:0];
                ptr_next = ptr_reg + CW'(1);
            end
            DP_UPDATE:
            begin
                wr_en        = 1'b1;
                wr_rec.price = item_reg.price_value;
                wr_rec.stock = item_reg.amount;
            end
            DP_WITHDRAW:
            begin
                wr_en              = 1'b1;
                wr_rec.stock       = rd_rec.stock - item_reg.amount;
                wr_rec.withdrawals = rd_rec.withdrawals + 32'd1;
            end
            default:
            begin
            end
        endcase
        if (dp_cmd.fill_inc)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (dp_cmd.fill_dec)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (dp_cmd.res_load)
        begin
            result_next.status = dp_cmd.res_status;
            if (dp_cmd.res_lookup)
            begin
                result_next.price_out       = rd_rec.price;
                result_next.stock_out       = rd_rec.stock;
                result_next.withdrawals_out = rd_rec.withdrawals;
            end
            else
            begin
                result_next.price_out       = '0;
                result_next.stock_out       = '0;
                result_next.withdrawals_out = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg   <= '0;
            hi_reg   <= '0;
            ptr_reg  <= '0;
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
            hit_reg  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // The fill count never exceeds the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill count beyond table depth");

    // A hit always leaves its slot inside the search window.
    a_hit_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (lo_reg < hi_reg))
        else $error("hit slot outside search window");

    // A record is only placed while a free entry remains.
    a_put_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.op == DP_INS_PUT) |-> !stat.full)
        else $error("insert placed into a full table");
`endif

endmodule

/* sv/sorted_record_table_unit.sv */
// Top level of the sorted record table: joins the controller and datapath.
// Depends on srt_pkg, srt_ctrl, srt_datapath and, through it, srt_ram.
//
//  Channel   Signals                 Transfer rule
//  -------   ---------------------   ---------------------------------------
//  command   start, busy, request    taken at a rising edge with start & !busy
//  result    result_valid, result    valid for one cycle, always taken
//
// Each transaction yields exactly one result. A binary search reads one
// probe at a time over the single read port of the record memory, each
// probe passing through the SEARCH and COMPARE states. Insert and remove
// then shift the records behind the slot one at a time through that port.
// Reset clears the fill count and the search and shift registers but not
// the record memory, which needs no clearing.
// The result side has no back-pressure: busy alone paces new commands.
module sorted_record_table_unit import srt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  srt_in_t  request,
    output logic     result_valid,
    output srt_out_t result
);

    // Command and status between the sequencer and the datapath.
    srt_dp_cmd_t  dp_cmd;
    srt_dp_stat_t dp_stat;

    // The controller walks the search, decides on the command and then
    // steps the shift one record per cycle.
    srt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .result_valid (result_valid),
        .stat         (dp_stat),
        .dp_cmd       (dp_cmd)
    );

    // The datapath holds the records in one memory, ordered by key, and
    // latches the transaction's fields when it is accepted.
    srt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .dp_cmd  (dp_cmd),
        .stat    (dp_stat),
        .result  (result)
    );

endmodule

/* dv/srt_table_checker.sv */
// Checker for the sorted record table: keeps its own copy of the table,
// predicts one result per accepted command and compares the results that arrive.
// Depends on srt_pkg for the command, status and payload types.
module srt_table_checker import srt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  srt_in_t  request,
    input  logic     result_valid,
    input  srt_out_t result,
    output int       mismatches,
    output int       waiting,
    output int       checked,
    output int       full_count,
    output int       short_count
);

    logic [63:0] rec_key         [TABLE_DEPTH];
    logic [31:0] rec_price       [TABLE_DEPTH];
    logic [31:0] rec_stock       [TABLE_DEPTH];
    logic [31:0] rec_withdrawals [TABLE_DEPTH];
    int          fill = 0;

    srt_out_t    expected_results [$];
    int          bad_total    = 0;
    int          result_total = 0;
    int          full_total   = 0;
    int          short_total  = 0;

    // Applies one command to the shadow table and returns its answer.
    // The table is kept sorted, so the first slot whose key is not below
    // the requested one is either the match or the insertion point.
    function automatic srt_out_t execute_command(srt_in_t req);
        int       slot;
        logic     hit;
        srt_out_t outcome;
        outcome = '0;
        slot = 0;
        while (slot < fill && rec_key[slot] < req.key)
            slot++;
        hit = (slot < fill) && (rec_key[slot] == req.key);
        case (req.cmd)
            CMD_INSERT:
            begin
                if (hit)
                    outcome.status = ST_DUPLICATE;
                else if (fill >= TABLE_DEPTH)
                    outcome.status = ST_FULL;
                else
                begin
                    for (int i = fill; i > slot; i--)
                    begin
                        rec_key[i]         = rec_key[i - 1];
                        rec_price[i]       = rec_price[i - 1];
                        rec_stock[i]       = rec_stock[i - 1];
                        rec_withdrawals[i] = rec_withdrawals[i - 1];
                    end
                    rec_key[slot]         = req.key;
                    rec_price[slot]       = req.price_value;
                    rec_stock[slot]       = req.amount;
                    rec_withdrawals[slot] = '0;
                    fill++;
                end
            end
            CMD_REMOVE:
            begin
                if (!hit)
                    outcome.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = slot; i + 1 < fill; i++)
                    begin
                        rec_key[i]         = rec_key[i + 1];
                        rec_price[i]       = rec_price[i + 1];
                        rec_stock[i]       = rec_stock[i + 1];
                        rec_withdrawals[i] = rec_withdrawals[i + 1];
                    end
                    fill--;
                end
            end
            CMD_LOOKUP:
            begin
                if (!hit)
                    outcome.status = ST_NOT_FOUND;
                else
                begin
                    outcome.price_out       = rec_price[slot];
                    outcome.stock_out       = rec_stock[slot];
                    outcome.withdrawals_out = rec_withdrawals[slot];
                end
            end
            CMD_UPDATE:
            begin
                if (!hit)
                    outcome.status = ST_NOT_FOUND;
                else
                begin
                    rec_price[slot] = req.price_value;
                    rec_stock[slot] = req.amount;
                end
            end
            CMD_WITHDRAW:
            begin
                if (!hit)
                    outcome.status = ST_NOT_FOUND;
                else if (rec_stock[slot] < req.amount)
                    outcome.status = ST_SHORT;
                else
                begin
                    rec_stock[slot]       = rec_stock[slot] - req.amount;
                    rec_withdrawals[slot] = rec_withdrawals[slot] + 32'd1;
                end
            end
            default:
            begin
                // Unused command codes leave the table alone and answer all zeros.
            end
        endcase
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        srt_out_t want;
        logic     bad;
        if (!rst_n)
        begin
            fill = 0;
            expected_results.delete();
        end
        else
        begin
            // Results are handled before the new command of the same edge;
            // a command can never be answered at the edge that takes it.
            if (result_valid)
            begin
                result_total++;
                if (expected_results.size() == 0)
                begin
                    bad_total++;
                    if (bad_total <= 10)
                        $display("Unexpected result with no command outstanding: status %0d",
                                 result.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    bad = (result.status !== want.status)
                        || (result.price_out !== want.price_out)
                        || (result.stock_out !== want.stock_out)
                        || (result.withdrawals_out !== want.withdrawals_out);
                    if (bad)
                    begin
                        bad_total++;
                        if (bad_total <= 10)
                        begin
                            $display("Mismatch on result %0d: expected status %0d price %0h",
                                     result_total, want.status, want.price_out);
                            $display("    stock %0h withdrawals %0h; got status %0d price %0h",
                                     want.stock_out, want.withdrawals_out,
                                     result.status, result.price_out);
                            $display("    stock %0h withdrawals %0h",
                                     result.stock_out, result.withdrawals_out);
                        end
                    end
                end
            end
            if (start && !busy)
            begin
                want = execute_command(request);
                expected_results = {expected_results, want};
                if (want.status == ST_FULL)
                    full_total++;
                if (want.status == ST_SHORT)
                    short_total++;
            end
        end
        mismatches  <= bad_total;
        waiting     <= expected_results.size();
        checked     <= result_total;
        full_count  <= full_total;
        short_count <= short_total;
    end

endmodule

/* dv/sorted_record_table_unit_test.sv */
// Testbench top for the sorted record table: drives commands and gives the verdict.
// Depends on srt_pkg, sorted_record_table_unit and srt_table_checker.
module sorted_record_table_unit_test;
    import srt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    // The key pool is larger than the table so that fill phases run into a
    // full table, yet small enough that most commands hit a stored record.
    localparam int KEY_POOL      = 96;
    localparam int SEGMENT_ITEMS = 237;
    localparam int SEGMENTS      = 8;
    // Sender gaps are short, so
    // this many cycles without any transaction or result means a hang.
    localparam int STALL_LIMIT   = 5000;
    localparam int TAIL_CYCLES   = 100;

    typedef enum int {
        MIX_FILL,
        MIX_BALANCED,
        MIX_DRAIN
    } mix_t;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    srt_in_t  request;
    logic     result_valid;
    srt_out_t result;

    int mismatches;
    int waiting;
    int checked;
    int full_count;
    int short_count;

    logic [63:0] key_pool [KEY_POOL];
    int          issued       = 0;
    int          quiet_cycles = 0;

    // Each random segment pairs a command mix with a sender idle rate, so
    // that fills, drains and mixed traffic all see gaps and back-to-back
    // transactions.
    mix_t seg_mix  [SEGMENTS] = '{MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_FILL,
                                  MIX_BALANCED, MIX_DRAIN, MIX_FILL, MIX_DRAIN};
    int   seg_idle [SEGMENTS] = '{0, 78, 31, 78, 0, 31, 78, 0};

    always #1 clk = ~clk;

    sorted_record_table_unit #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    srt_table_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) table_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .mismatches   (mismatches),
        .waiting      (waiting),
        .checked      (checked),
        .full_count   (full_count),
        .short_count  (short_count)
    );

    // A key built the way names are stored: one to eight lowercase
    // characters, the first one in the top byte, zero padding below.
    function automatic logic [63:0] name_key();
        int          len;
        logic [63:0] k;
        len = $urandom_range(1, 8);
        k = '0;
        for (int i = 0; i < 8; i++)
            k = {k[55:0], (i < len) ? 8'($urandom_range(97, 122)) : 8'h00};
        return k;
    endfunction

    function automatic srt_in_t make_request(logic [2:0] cmd, logic [63:0] key,
                                             logic [31:0] price, logic [31:0] amount);
        srt_in_t req;
        req.cmd         = cmd;
        req.key         = key;
        req.price_value = price;
        req.amount      = amount;
        return req;
    endfunction

    // Random command whose mix of operations depends on the segment. Keys
    // come mostly from the pool; one in ten is a fresh random key, which
    // is almost always a miss. Stock values are often small so that
    // withdrawals both succeed and run short.
    function automatic srt_in_t random_command(mix_t mix);
        int      roll;
        int      pick;
        int      ins_cut;
        int      rem_cut;
        int      look_cut;
        int      upd_cut;
        srt_in_t req;
        case (mix)
            MIX_FILL:
            begin
                ins_cut = 55; rem_cut = 62; look_cut = 75; upd_cut = 82;
            end
            MIX_DRAIN:
            begin
                ins_cut = 8; rem_cut = 60; look_cut = 75; upd_cut = 82;
            end
            default:
            begin
                ins_cut = 25; rem_cut = 45; look_cut = 65; upd_cut = 75;
            end
        endcase
        if ($urandom_range(0, 9) == 0)
            req.key = {$urandom, $urandom};
        else
            req.key = key_pool[$urandom_range(0, KEY_POOL - 1)];
        req.price_value = $urandom;
        if ($urandom_range(0, 1) == 0)
            req.amount = $urandom_range(0, 200);
        else
            req.amount = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < ins_cut)
            req.cmd = CMD_INSERT;
        else if (roll < rem_cut)
            req.cmd = CMD_REMOVE;
        else if (roll < look_cut)
            req.cmd = CMD_LOOKUP;
        else if (roll < upd_cut)
            req.cmd = CMD_UPDATE;
        else if (roll < 97)
        begin
            req.cmd = CMD_WITHDRAW;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                req.amount = '0;
            else if (pick < 7)
                req.amount = $urandom_range(0, 60);
            else
                req.amount = $urandom;
        end
        else
            req.cmd = 3'($urandom_range(5, 7));
        return req;
    endfunction

    // Offers one command, idling first with the given chance per cycle.
    // While idle the request bus carries random values that must be
    // ignored. Inputs change only at falling edges; the transaction is
    // taken at the first rising edge at which busy is low.
    task automatic send(srt_in_t req, int idle_pct);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start   <= 1'b0;
            request <= make_request(3'($urandom), {$urandom, $urandom}, $urandom, $urandom);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        issued++;
    endtask

    // Holds the sender off until every expected result has come back.
    // The count is read at falling edges, after the checker has updated it.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
    endtask

    // Watchdog: counts cycles in which no transaction is taken and no
    // result appears.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
                     quiet_cycles, waiting);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [63:0] top_key;
        logic [63:0] mid_key;
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;

        // Pool: the two extreme keys, name-like keys and full-width random
        // keys, so that every key bit is seen both ways.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL / 2; i++)
            key_pool[i] = name_key();
        for (int i = KEY_POOL / 2; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: extreme keys and values, every command, duplicate
        // insert, misses of each kind, a withdraw of the whole stock, a
        // withdraw that runs short, a withdraw of zero that still counts,
        // the unused command codes, and removal down to an empty table.
        // A full table is reached in the fill segments further on.
        top_key = '1;
        mid_key = 64'h6d69_6464_6c65_0000;
        send(make_request(CMD_INSERT,   '0,      '0,     '0),     0);
        send(make_request(CMD_INSERT,   top_key, '1,     '1),     0);
        send(make_request(CMD_INSERT,   top_key, 32'd7,  32'd7),  0);
        send(make_request(CMD_LOOKUP,   '0,      '1,     '1),     0);
        send(make_request(CMD_LOOKUP,   top_key, '0,     '0),     0);
        send(make_request(CMD_LOOKUP,   mid_key, '0,     '0),     0);
        send(make_request(CMD_WITHDRAW, top_key, '0,     '1),     0);
        send(make_request(CMD_WITHDRAW, top_key, '0,     32'd1),  0);
        send(make_request(CMD_WITHDRAW, '0,      '0,     '0),     0);
        send(make_request(CMD_LOOKUP,   '0,      '0,     '0),     0);
        send(make_request(CMD_UPDATE,   top_key, 32'd5,  32'd10), 0);
        send(make_request(CMD_UPDATE,   mid_key, 32'd5,  32'd10), 0);
        send(make_request(CMD_WITHDRAW, mid_key, '0,     32'd1),  0);
        send(make_request(CMD_LOOKUP,   top_key, '0,     '0),     0);
        send(make_request(3'd5,         top_key, '1,     '1),     0);
        send(make_request(3'd6,         '0,      '1,     '1),     0);
        send(make_request(3'd7,         top_key, '0,     '0),     0);
        send(make_request(CMD_REMOVE,   '0,      '0,     '0),     0);
        send(make_request(CMD_REMOVE,   '0,      '0,     '0),     0);
        send(make_request(CMD_INSERT,   mid_key, 32'd3,  32'd4),  0);
        send(make_request(CMD_REMOVE,   top_key, '0,     '0),     0);
        send(make_request(CMD_LOOKUP,   mid_key, '0,     '0),     0);
        send(make_request(CMD_REMOVE,   mid_key, '0,     '0),     0);
        drain();

        // Random part, segment by segment, with a full drain between
        // segments so the sender also pauses with nothing in flight.
        for (int s = 0; s < SEGMENTS; s++)
        begin
            for (int n = 0; n < SEGMENT_ITEMS; n++)
                send(random_command(seg_mix[s]), seg_idle[s]);
            drain();
        end

        // Leave room for a late or extra result to show up.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d commands: fill, mixed and drain mixes at idle rates 0, 31, 78.",
                 issued);
        $display("Results checked: %0d; full-table rejections %0d; short withdrawals %0d.",
                 checked, full_count, short_count);
        if (mismatches == 0 && waiting == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
sv/srt_pkg.sv
sv/srt_ram.sv
sv/srt_ctrl.sv
sv/srt_datapath.sv
sv/sorted_record_table_unit.sv
dv/srt_table_checker.sv
dv/sorted_record_table_unit_test.sv
